/* design/uitp_pkg.sv */
// uitp_pkg: shared types and constants for the unsigned integer text parser
`timescale 1ns / 1ps
`default_nettype none

package uitp_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned BASE_W      = 6;
    localparam int unsigned ACC_W       = 64;
    localparam int unsigned OFF_W       = 12;
    localparam int unsigned MAX_LEN_DEF = 4095;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_SOME,
        ST_OVER
    } status_t;

    typedef struct packed {
        logic              start_req;
        logic [CHAR_W-1:0] char_code;
        logic [BASE_W-1:0] base;
    } in_t;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             overflow;
        logic             no_digits;
        logic [OFF_W-1:0] end_offset;
    } out_t;

    // parse state carried from one character to the next
    typedef struct packed {
        phase_t            phase;
        logic [BASE_W-1:0] active_base;
        logic [ACC_W-1:0]  accumulator;
        logic              negative;
        status_t           digit_status;
    } state_t;

endpackage

`default_nettype wire

/* design/uitp_step.sv */
// uitp_step: next parse state and result for one character
`timescale 1ns / 1ps
`default_nettype none

module uitp_step #(
    parameter int unsigned MAX_LEN = uitp_pkg::MAX_LEN_DEF,
    localparam int unsigned IDX_W  = $clog2(MAX_LEN + 1)
) (
    input  uitp_pkg::in_t    item,
    input  uitp_pkg::state_t state,
    input  logic [IDX_W-1:0] idx,
    output uitp_pkg::state_t state_upd,
    output logic [IDX_W-1:0] idx_upd,
    output logic             emit,
    output uitp_pkg::out_t   result
);
    import uitp_pkg::*;

    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_B   = 8'h42;
    localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_B   = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LO_X   = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] UP_OFFSET = 8'd55;
    localparam logic [CHAR_W-1:0] LO_OFFSET = 8'd87;
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_BIN  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam int unsigned       PROD_W    = ACC_W + BASE_W;
    localparam int unsigned       SUM_W     = PROD_W + 1;

    state_t            cur;
    logic [IDX_W-1:0]  cur_idx;
    logic [CHAR_W-1:0] ch;

    phase_t            phase_sel;
    logic [BASE_W-1:0] base_eff;
    logic              neg_sel;
    logic              take;
    logic              zero_case;

    logic [CHAR_W-1:0] digit_wide;
    logic              is_char_digit;
    logic              digit_ok;
    logic [ACC_W-1:0]  acc_in;
    status_t           status_in;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;
    logic              mul_ovf;
    logic              done;
    logic [ACC_W-1:0]  acc_new;
    status_t           status_new;

    logic [OFF_W+IDX_W-1:0] idx_ext;

    assign ch = item.char_code;

    // a start character begins from a fresh state
    always_comb
    begin
        cur     = state;
        cur_idx = idx;
        if (item.start_req)
        begin
            cur.phase        = PH_SPACE;
            cur.active_base  = item.base;
            cur.accumulator  = '0;
            cur.negative     = 1'b0;
            cur.digit_status = ST_NONE;
            cur_idx          = '0;
        end
    end

    // next phase and base selection
    always_comb
    begin
        phase_sel = cur.phase;
        base_eff  = cur.active_base;
        neg_sel   = cur.negative;
        take      = 1'b0;
        zero_case = 1'b0;
        unique case (cur.phase) inside
            PH_IDLE:
            begin
            end
            PH_SPACE, PH_SIGNED:
            begin
                if (cur.phase == PH_SPACE &&
                    (ch == CH_SPACE || ch == CH_TAB || ch == CH_NL))
                begin
                    phase_sel = PH_SPACE;
                end
                else if (cur.phase == PH_SPACE && ch == CH_MINUS)
                begin
                    neg_sel   = 1'b1;
                    phase_sel = PH_SIGNED;
                end
                else if (cur.phase == PH_SPACE && ch == CH_PLUS)
                begin
                    phase_sel = PH_SIGNED;
                end
                else if (ch == CH_ZERO &&
                         (cur.active_base == BASE_AUTO || cur.active_base == BASE_HEX ||
                          cur.active_base == BASE_BIN))
                begin
                    phase_sel = PH_ZERO;
                end
                else
                begin
                    if (cur.active_base == BASE_AUTO)
                    begin
                        base_eff = BASE_DEC;
                    end
                    phase_sel = PH_DIGITS;
                    take      = 1'b1;
                end
            end
            PH_ZERO:
            begin
                if ((cur.active_base == BASE_AUTO || cur.active_base == BASE_HEX) &&
                    (ch == CH_LO_X || ch == CH_UP_X))
                begin
                    base_eff  = BASE_HEX;
                    phase_sel = PH_DIGITS;
                end
                else if ((cur.active_base == BASE_AUTO || cur.active_base == BASE_BIN) &&
                         (ch == CH_LO_B || ch == CH_UP_B))
                begin
                    base_eff  = BASE_BIN;
                    phase_sel = PH_DIGITS;
                end
                else
                begin
                    // the leading zero counts as a digit of value zero
                    if (cur.active_base == BASE_AUTO)
                    begin
                        base_eff = BASE_OCT;
                    end
                    phase_sel = PH_DIGITS;
                    zero_case = 1'b1;
                    take      = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                take = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // digit decode and multiply-add
    always_comb
    begin
        is_char_digit = 1'b1;
        digit_wide    = '0;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            digit_wide = ch - CH_ZERO;
        end
        else if (ch >= CH_UP_A && ch <= CH_UP_Z)
        begin
            digit_wide = ch - UP_OFFSET;
        end
        else if (ch >= CH_LO_A && ch <= CH_LO_Z)
        begin
            digit_wide = ch - LO_OFFSET;
        end
        else
        begin
            is_char_digit = 1'b0;
        end
        digit_ok  = is_char_digit && (base_eff != BASE_AUTO) &&
                    (digit_wide[BASE_W-1:0] < base_eff);
        acc_in    = zero_case ? '0 : cur.accumulator;
        status_in = zero_case ? ST_SOME : cur.digit_status;
        prod      = {{BASE_W{1'b0}}, acc_in} * {{ACC_W{1'b0}}, base_eff};
        sum       = {1'b0, prod} + SUM_W'(digit_wide[BASE_W-1:0]);
        mul_ovf   = |sum[SUM_W-1:ACC_W];
        done      = take && !digit_ok;
        if (status_in == ST_OVER || mul_ovf)
        begin
            acc_new    = acc_in;
            status_new = ST_OVER;
        end
        else
        begin
            acc_new    = sum[ACC_W-1:0];
            status_new = ST_SOME;
        end
    end

    // state update
    always_comb
    begin
        state_upd             = cur;
        state_upd.phase       = done ? PH_IDLE : phase_sel;
        state_upd.active_base = base_eff;
        state_upd.negative    = neg_sel;
        if (take && digit_ok)
        begin
            state_upd.accumulator  = acc_new;
            state_upd.digit_status = status_new;
        end
        if (done || cur.phase == PH_IDLE || cur_idx >= IDX_W'(MAX_LEN))
        begin
            idx_upd = cur_idx;
        end
        else
        begin
            idx_upd = cur_idx + IDX_W'(1);
        end
    end

    // result of a terminating character
    always_comb
    begin
        idx_ext = {{OFF_W{1'b0}}, cur_idx};
        emit    = done;
        if (status_in == ST_OVER)
        begin
            result.value = '1;
        end
        else if (cur.negative)
        begin
            result.value = '0 - acc_in;
        end
        else
        begin
            result.value = acc_in;
        end
        result.overflow   = (status_in == ST_OVER);
        result.no_digits  = (status_in == ST_NONE);
        result.end_offset = (status_in == ST_NONE) ? '0 : idx_ext[OFF_W-1:0];
    end

endmodule

`default_nettype wire

/* design/unsigned_integer_text_parser.sv */
// unsigned_integer_text_parser: streaming text to 64-bit unsigned integer parser
//
//   channel  direction  payload               handshake
//   char     in         uitp_pkg::in_t        char_valid / char_stall
//   result   out        uitp_pkg::out_t       result_valid / result_stall
//
// one character per cycle while char_stall is low; result_valid rises once the terminating
// character has passed the input register, then the result register
// the per-cycle path is one 64 x 6 bit multiply-add plus the overflow check
// reset (rst_n low) leaves the parser idle; characters are ignored until a start
// a terminating character waits in the input register while the result stalls;
// characters that give no result keep moving
`timescale 1ns / 1ps
`default_nettype none

module unsigned_integer_text_parser #(
    parameter int unsigned MAX_LEN = uitp_pkg::MAX_LEN_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           char_valid,
    output logic           char_stall,
    input  uitp_pkg::in_t  char_data,
    output logic           result_valid,
    input  logic           result_stall,
    output uitp_pkg::out_t result_data
);
    import uitp_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_LEN + 1);

    in_t              item_reg;
    logic             item_valid_reg;
    logic             item_valid_next;
    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    out_t             result_reg;
    logic             result_valid_reg;
    logic             result_valid_next;

    state_t           step_state;
    logic [IDX_W-1:0] step_idx;
    logic             step_emit;
    out_t             step_result;

    logic             char_xfer;
    logic             can_load;
    logic             advance;

    uitp_step #(
        .MAX_LEN (MAX_LEN)
    ) u_step (
        .item      (item_reg),
        .state     (state_reg),
        .idx       (idx_reg),
        .state_upd (step_state),
        .idx_upd   (step_idx),
        .emit      (step_emit),
        .result    (step_result)
    );

    assign can_load   = !result_valid_reg || !result_stall;
    assign advance    = item_valid_reg && (!step_emit || can_load);
    assign char_stall = item_valid_reg && !advance;
    assign char_xfer  = char_valid && !char_stall;

    always_comb
    begin
        state_next = advance ? step_state : state_reg;
        idx_next   = advance ? step_idx : idx_reg;
        if (char_xfer)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
        result_valid_next = can_load ? (advance && step_emit) : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg         <= 1'b0;
            result_valid_reg       <= 1'b0;
            state_reg.phase        <= PH_IDLE;
            state_reg.active_base  <= '0;
            state_reg.accumulator  <= '0;
            state_reg.negative     <= 1'b0;
            state_reg.digit_status <= ST_NONE;
            idx_reg                <= '0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
            state_reg        <= state_next;
            idx_reg          <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (char_xfer)
        begin
            item_reg <= char_data;
        end
        if (can_load && advance && step_emit)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule

`default_nettype wire

/* tb/unsigned_integer_text_parser_tb.sv */
// unsigned_integer_text_parser_tb: self-checking testbench for the streaming text to integer parser
`timescale 1ns / 1ps

module unsigned_integer_text_parser_tb;
    import uitp_pkg::*;

    localparam int unsigned HALF_PERIOD  = 6;
    localparam int unsigned RESET_CYCLES = 5;
    localparam int unsigned IDLE_LIMIT   = 5000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned RANDOM_CHARS = 950;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int          NO_TERM      = -1;

    localparam logic [7:0] NUL       = 8'h00;
    localparam logic [7:0] TAB       = 8'h09;
    localparam logic [7:0] LF        = 8'h0A;
    localparam logic [7:0] SP        = 8'h20;
    localparam logic [7:0] PLUS      = 8'h2B;
    localparam logic [7:0] MINUS     = 8'h2D;
    localparam logic [7:0] DIGIT_0   = 8'h30;
    localparam logic [7:0] UPPER_OFS = 8'd55;
    localparam logic [7:0] LOWER_OFS = 8'd87;

    localparam logic [ACC_W-1:0] ALL_ONES = {ACC_W{1'b1}};
    localparam out_t             NO_WANT  = '0;

    typedef struct {
        string       text;
        int          term;
        logic [5:0]  base;
        bit          typed;
        out_t        want;
    } dir_row_t;

    localparam int DIR_ROWS = 20;

    // directed strings; typed rows carry their result, the rest go through the predictor
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{"",                     NUL,     6'd0,  1'b1, {64'd0, 1'b0, 1'b1, 12'd0}},
        '{"  \t\n+42",            NUL,     6'd10, 1'b1, {64'd42, 1'b0, 1'b0, 12'd7}},
        '{"-1",                   8'hFF,   6'd10, 1'b1, {ALL_ONES, 1'b0, 1'b0, 12'd2}},
        '{"0x",                   "g",     6'd0,  1'b1, {64'd0, 1'b0, 1'b1, 12'd0}},
        '{"0B101",                "2",     6'd0,  1'b0, NO_WANT},
        '{"017",                  "8",     6'd0,  1'b0, NO_WANT},
        '{"-",                    SP,      6'd16, 1'b1, {64'd0, 1'b0, 1'b1, 12'd0}},
        '{"000",                  "1",     6'd1,  1'b1, {64'd0, 1'b0, 1'b0, 12'd3}},
        '{"zz",                   NUL,     6'd63, 1'b0, NO_WANT},
        '{"zzzzzzzzzzzzz",        NUL,     6'd36, 1'b1, {ALL_ONES, 1'b1, 1'b0, 12'd13}},
        '{"-ffffffffffffffff",    NUL,     6'd16, 1'b0, NO_WANT},
        '{"-10000000000000000",   NUL,     6'd16, 1'b1, {ALL_ONES, 1'b1, 1'b0, 12'd18}},
        '{"12",                   NO_TERM, 6'd10, 1'b0, NO_WANT},
        '{"7",                    "9",     6'd8,  1'b1, {64'd7, 1'b0, 1'b0, 12'd1}},
        '{"0xAz",                 NUL,     6'd16, 1'b0, NO_WANT},
        '{"0b1",                  NUL,     6'd16, 1'b0, NO_WANT},
        '{"0x",                   NUL,     6'd2,  1'b1, {64'd0, 1'b0, 1'b0, 12'd1}},
        '{"18446744073709551615", NUL,     6'd10, 1'b1, {ALL_ONES, 1'b0, 1'b0, 12'd20}},
        '{"18446744073709551616", NUL,     6'd10, 1'b1, {ALL_ONES, 1'b1, 1'b0, 12'd20}},
        '{"9",                    ":",     6'd0,  1'b1, {64'd9, 1'b0, 1'b0, 12'd1}}
    };

    localparam logic [7:0] BLANKS [3] = '{SP, TAB, LF};

    logic clk          = 1'b0;
    logic rst_n        = 1'b0;
    logic char_valid   = 1'b0;
    logic result_stall = 1'b0;
    in_t  char_data    = '0;
    logic char_stall;
    logic result_valid;
    out_t result_data;

    unsigned_integer_text_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // predictor state
    phase_t           ps_phase  = PH_IDLE;
    logic [5:0]       ps_base   = '0;
    logic [ACC_W-1:0] ps_acc    = '0;
    logic             ps_neg    = 1'b0;
    status_t          ps_status = ST_NONE;
    int unsigned      ps_index  = 0;

    out_t        pending_numbers [$];
    bit          typed_pending = 1'b0;
    out_t        typed_result  = '0;
    bit          quiet         = 1'b0;
    int unsigned stall_left    = 0;
    int unsigned idle_cycles   = 0;
    int unsigned chars_parsed  = 0;
    int unsigned chars_sent    = 0;
    int unsigned strings_sent  = 0;
    int unsigned results_seen  = 0;
    int unsigned overflows     = 0;
    int unsigned empty_parses  = 0;
    int unsigned mismatches    = 0;

    function automatic int unsigned gap_len();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offers one character as a digit; 1 means it ends the parse
    function automatic bit digit_ends_parse(logic [7:0] ch);
        logic [ACC_W-1:0] b;
        logic [ACC_W-1:0] d;
        logic [ACC_W-1:0] lim;
        b = {58'd0, ps_base};
        if (ch >= "0" && ch <= "9")
            d = {56'd0, 8'(ch - DIGIT_0)};
        else if (ch >= "A" && ch <= "Z")
            d = {56'd0, 8'(ch - UPPER_OFS)};
        else if (ch >= "a" && ch <= "z")
            d = {56'd0, 8'(ch - LOWER_OFS)};
        else
            return 1'b1;
        if (b == '0 || d >= b)
            return 1'b1;
        lim = ALL_ONES / b;
        if (ps_status == ST_OVER || ps_acc > lim || (ps_acc == lim && d > ALL_ONES % b))
            ps_status = ST_OVER;
        else
        begin
            ps_status = ST_SOME;
            ps_acc    = ps_acc * b + d;
        end
        return 1'b0;
    endfunction

    function automatic bit parse_char(input in_t c, output out_t r);
        logic [7:0] ch;
        bit         done;
        ch   = c.char_code;
        done = 1'b0;
        r    = '0;
        if (c.start_req)
        begin
            ps_phase  = PH_SPACE;
            ps_base   = c.base;
            ps_acc    = '0;
            ps_neg    = 1'b0;
            ps_status = ST_NONE;
            ps_index  = 0;
        end
        if (ps_phase == PH_IDLE)
            return 1'b0;
        chars_parsed++;
        case (ps_phase) inside
            PH_SPACE, PH_SIGNED:
            begin
                if (ps_phase == PH_SPACE && ch == MINUS)
                begin
                    ps_neg   = 1'b1;
                    ps_phase = PH_SIGNED;
                end
                else if (ps_phase == PH_SPACE && ch == PLUS)
                    ps_phase = PH_SIGNED;
                else if (ps_phase == PH_SIGNED || !(ch == SP || ch == TAB || ch == LF))
                begin
                    if (ch == DIGIT_0 && (ps_base == 6'd0 || ps_base == 6'd16 || ps_base == 6'd2))
                        ps_phase = PH_ZERO;
                    else
                    begin
                        if (ps_base == 6'd0)
                            ps_base = 6'd10;
                        ps_phase = PH_DIGITS;
                        done     = digit_ends_parse(ch);
                    end
                end
            end
            PH_ZERO:
            begin
                if ((ps_base == 6'd0 || ps_base == 6'd16) && (ch == "x" || ch == "X"))
                begin
                    ps_base  = 6'd16;
                    ps_phase = PH_DIGITS;
                end
                else if ((ps_base == 6'd0 || ps_base == 6'd2) && (ch == "b" || ch == "B"))
                begin
                    ps_base  = 6'd2;
                    ps_phase = PH_DIGITS;
                end
                else
                begin
                    // no prefix after all: the leading zero counts as a digit
                    if (ps_base == 6'd0)
                        ps_base = 6'd8;
                    ps_phase = PH_DIGITS;
                    void'(digit_ends_parse(DIGIT_0));
                    done = digit_ends_parse(ch);
                end
            end
            default:
                done = digit_ends_parse(ch);
        endcase
        if (done)
        begin
            if (ps_status == ST_OVER)
                r.value = ALL_ONES;
            else
                r.value = ps_neg ? -ps_acc : ps_acc;
            r.overflow   = (ps_status == ST_OVER);
            r.no_digits  = (ps_status == ST_NONE);
            r.end_offset = (ps_status == ST_NONE) ? '0 : 12'(ps_index);
            ps_phase     = PH_IDLE;
            return 1'b1;
        end
        if (ps_index < MAX_LEN_DEF)
            ps_index++;
        return 1'b0;
    endfunction

    // one character transfer; the predictor runs on acceptance
    task automatic send_char(input logic start, input logic [7:0] ch, input logic [5:0] sel);
        int unsigned gap;
        out_t        r;
        gap = gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= {start, ch, sel};
        do
            @(posedge clk);
        while (char_stall);
        chars_sent++;
        if (parse_char({start, ch, sel}, r))
        begin
            if (typed_pending)
            begin
                pending_numbers.push_back(typed_result);
                typed_pending = 1'b0;
            end
            else
                pending_numbers.push_back(r);
        end
    endtask

    task automatic flag_mismatch(input string why, input out_t want, input out_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s: expected %h ovf %0b none %0b off %0d, got %h ovf %0b none %0b off %0d",
                     why, want.value, want.overflow, want.no_digits, want.end_offset,
                     got.value, got.overflow, got.no_digits, got.end_offset);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && stall_left == 0 && $urandom_range(0, 3) == 0)
            stall_left = gap_len();
        result_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (result_data.overflow)
                overflows++;
            if (result_data.no_digits)
                empty_parses++;
            if (pending_numbers.size() == 0)
                flag_mismatch("result with nothing pending", NO_WANT, result_data);
            else
            begin
                want = pending_numbers.pop_front();
                if (want.value !== result_data.value || want.overflow !== result_data.overflow
                    || want.no_digits !== result_data.no_digits
                    || want.end_offset !== result_data.end_offset)
                    flag_mismatch("result mismatch", want, result_data);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((char_valid && !char_stall) || (result_valid && !result_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned first_parsed;
        int unsigned eff;
        int unsigned dmax;
        int unsigned n;
        int unsigned r;
        int          len;
        logic [5:0]  b;
        logic [7:0]  ch;
        logic [7:0]  d;
        logic [7:0]  txt [$];
        bit          maxed;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // characters before any start are ignored
        send_char(1'b0, "7", 6'd0);
        send_char(1'b0, 8'hFF, 6'h3F);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            typed_pending = dir_rows[i].typed;
            typed_result  = dir_rows[i].want;
            len           = dir_rows[i].text.len();
            for (int k = 0; k < len; k++)
                send_char(k == 0, dir_rows[i].text[k], dir_rows[i].base);
            if (dir_rows[i].term != NO_TERM)
                send_char(len == 0, 8'(dir_rows[i].term), dir_rows[i].base);
        end

        first_parsed = chars_parsed;
        while (chars_parsed - first_parsed < RANDOM_CHARS)
        begin
            if ($urandom_range(0, 29) == 0)
                quiet = !quiet;
            txt.delete();

            // stray characters, taken while idle or as the tail of an open parse
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 4))
                    send_char(1'b0, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));

            r = $urandom_range(0, 99);
            if (r < 25)
                b = 6'd0;
            else if (r < 37)
                b = 6'd10;
            else if (r < 49)
                b = 6'd16;
            else if (r < 57)
                b = 6'd8;
            else if (r < 64)
                b = 6'd2;
            else if (r < 69)
                b = 6'd36;
            else if (r < 72)
                b = 6'd1;
            else
                b = 6'($urandom_range(0, 63));
            eff = (b == 6'd0) ? 10 : 32'(b);

            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    txt.push_back(BLANKS[$urandom_range(0, 2)]);
            r = $urandom_range(0, 9);
            if (r < 2)
                txt.push_back(MINUS);
            else if (r == 2)
                txt.push_back(PLUS);

            r = $urandom_range(0, 9);
            if ((b == 6'd0 || b == 6'd16) && r < 3)
            begin
                txt.push_back(DIGIT_0);
                txt.push_back((r == 0) ? "X" : "x");
                eff = 16;
            end
            else if ((b == 6'd0 || b == 6'd2) && r >= 3 && r < 5)
            begin
                txt.push_back(DIGIT_0);
                txt.push_back((r == 3) ? "B" : "b");
                eff = 2;
            end
            else if (b == 6'd0 && r >= 5 && r < 7)
            begin
                txt.push_back(DIGIT_0);
                eff = 8;
            end

            // letters stop at z, whatever the base
            dmax  = (eff > 36) ? 35 : eff - 1;
            r     = $urandom_range(0, 9);
            n     = (r < 7) ? $urandom_range(1, 6)
                  : (r < 9) ? $urandom_range(7, 20) : $urandom_range(21, 70);
            maxed = ($urandom_range(0, 9) == 0);
            repeat (n)
            begin
                if ($urandom_range(0, 19) == 0)
                    ch = 8'($urandom_range(0, 255));
                else
                begin
                    d = maxed ? 8'(dmax) : 8'($urandom_range(0, dmax));
                    if (d < 8'd10)
                        ch = DIGIT_0 + d;
                    else
                        ch = ($urandom_range(0, 1) ? UPPER_OFS : LOWER_OFS) + d;
                end
                txt.push_back(ch);
            end

            // mostly terminated; an open string is dropped by the next start
            if ($urandom_range(0, 19) != 0)
                txt.push_back($urandom_range(0, 1) ? NUL : 8'($urandom_range(0, 255)));

            foreach (txt[k])
                send_char(k == 0, txt[k], (k == 0) ? b : 6'($urandom_range(0, 63)));
            strings_sent++;
        end
        @(negedge clk);
        char_valid <= 1'b0;

        while (pending_numbers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d random strings plus directed cases, %0d characters sent, %0d parsed",
                 strings_sent, chars_sent, chars_parsed);
        $display("%0d results checked (%0d overflowed, %0d without digits), %0d mismatches",
                 results_seen, overflows, empty_parses, mismatches);
        if (mismatches == 0 && pending_numbers.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
design/uitp_pkg.sv
design/uitp_step.sv
design/unsigned_integer_text_parser.sv
tb/unsigned_integer_text_parser_tb.sv
